// File: rtl/tis_pkg.sv
// shared types and constants of the turret index sequencer
package tis_pkg;

   // default number of turret positions
   localparam int POSITIONS_DEF = 6;

   // field widths
   localparam int TICK_W = 16;
   localparam int TOOL_W = 3;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam logic [TICK_W-1:0] CHANGE_TICKS_RST = 16'd45312;
   localparam logic [TICK_W-1:0] FIX_TICKS_RST = 16'd54687;
   localparam logic HOLD_VARIANT_RST = 1'b0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_VARIANT = 2'd2;

   // item modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_CMD = 1'b1;

   // variant codes
   localparam logic VARIANT_FIXING = 1'b0;

   // sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CHANGE,
      PH_FIX
   } phase_type;

   // one registered input item
   typedef struct packed {
      logic              mode;
      logic [TOOL_W-1:0] tool;
   } item_type;

   // configuration registers
   typedef struct packed {
      logic [TICK_W-1:0] change_ticks;
      logic [TICK_W-1:0] fix_ticks;
      logic              hold_variant;
   } cfg_type;

endpackage

// File: rtl/tis_in_stage.sv
// input register of the turret index sequencer
module tis_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [2:0]        req_tool,
   input  logic              advance,
   output logic              item_valid,
   output tis_pkg::item_type item
);
   import tis_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;

   // slot frees when the held item moves on
   assign req_ready = !vld_ff || advance;

   // next values of the input register
   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (advance) begin
         vld_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         vld_in       = 1'b1;
         item_in.mode = req_mode;
         item_in.tool = req_tool;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

// File: rtl/tis_update.sv
// sequencer state and its per-item update
module tis_update #(
   parameter int POSITIONS = tis_pkg::POSITIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tis_pkg::item_type item,
   input  tis_pkg::cfg_type  cfg,
   output logic              change_drive,
   output logic              fixing_drive,
   output logic              hold_drive,
   output logic              done_res,
   output logic [2:0]        position,
   output logic [2:0]        steps_left
);
   import tis_pkg::*;

   localparam int RW = $clog2(POSITIONS);
   localparam int PCW = $clog2(POSITIONS + 1);
   localparam int CW = (PCW > TOOL_W) ? PCW : TOOL_W;
   localparam int RXW = (RW > 3) ? RW : 3;

   phase_type         phase_ff, phase_in;
   logic [TOOL_W-1:0] pos_ff, pos_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              done_ff, done_in;
   logic              change_ff, change_in;
   logic              fixing_ff, fixing_in;
   logic              hold_ff, hold_in;

   logic [CW-1:0]     tool_ext, pos_ext, diff, steps_full;
   logic [RW-1:0]     steps, rem_dec;
   logic              in_range;
   logic [RXW-1:0]    rem_ext;

   // forward step count modulo the position count
   always_comb begin
      tool_ext   = CW'(item.tool);
      pos_ext    = CW'(pos_ff);
      diff       = tool_ext - pos_ext;
      in_range   = (item.tool != '0) && (tool_ext <= CW'(POSITIONS));
      steps_full = (tool_ext >= pos_ext) ? diff : (diff + CW'(POSITIONS));
      steps      = steps_full[RW-1:0];
      rem_dec    = (rem_ff != '0) ? (rem_ff - RW'(1)) : rem_ff;
   end

   // next state for one command or one tick
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      tick_in   = tick_ff;
      done_in   = done_ff;
      change_in = change_ff;
      fixing_in = fixing_ff;
      hold_in   = hold_ff;
      if (item.mode == MODE_CMD) begin
         // new target restarts the sequence, same target ignored
         if (in_range && (item.tool != pos_ff)) begin
            pos_in    = item.tool;
            rem_in    = steps;
            done_in   = 1'b0;
            phase_in  = PH_CHANGE;
            tick_in   = '0;
            change_in = 1'b1;
            if (cfg.hold_variant != VARIANT_FIXING) begin
               hold_in = 1'b0;
            end
         end
      end else begin
         case (phase_ff)
            PH_CHANGE: begin
               if (tick_ff != cfg.change_ticks) begin
                  tick_in = tick_ff + TICK_W'(1);
               end else begin
                  phase_in  = PH_FIX;
                  tick_in   = '0;
                  change_in = 1'b0;
                  if (cfg.hold_variant == VARIANT_FIXING) begin
                     fixing_in = 1'b1;
                  end
               end
            end
            PH_FIX: begin
               if (tick_ff != cfg.fix_ticks) begin
                  tick_in = tick_ff + TICK_W'(1);
               end else begin
                  tick_in = '0;
                  if (cfg.hold_variant == VARIANT_FIXING) begin
                     fixing_in = 1'b0;
                  end else begin
                     hold_in = 1'b1;
                  end
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     // next index step
                     phase_in  = PH_CHANGE;
                     change_in = 1'b1;
                     if (cfg.hold_variant != VARIANT_FIXING) begin
                        hold_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // state registers, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= TOOL_W'(1);
         rem_ff    <= '0;
         tick_ff   <= '0;
         done_ff   <= 1'b1;
         change_ff <= 1'b0;
         fixing_ff <= 1'b0;
         hold_ff   <= 1'b1;
      end else if (advance) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         rem_ff    <= rem_in;
         tick_ff   <= tick_in;
         done_ff   <= done_in;
         change_ff <= change_in;
         fixing_ff <= fixing_in;
         hold_ff   <= hold_in;
      end
   end

   // state doubles as the result register
   assign rem_ext      = RXW'(rem_ff);
   assign steps_left   = rem_ext[2:0];
   assign position     = pos_ff;
   assign change_drive = change_ff;
   assign fixing_drive = fixing_ff;
   assign hold_drive   = hold_ff;
   assign done_res     = done_ff;

endmodule

// File: rtl/turret_index_sequencer_core.sv
// turret index sequencer top level
// path: a req item passes the input register, then the result register, before rsp_valid rises
// throughput: one item per cycle while rsp_ready is high, the result register is the sequencer state itself
// a result waiting on rsp_ready stalls the next update, the input register still takes one item
// reset: synchronous, active high; outputs idle, position 1, done and hold high
// reset loads change_ticks 45312, fix_ticks 54687, hold_variant 0
module turret_index_sequencer_core #(
   parameter int POSITIONS = tis_pkg::POSITIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [2:0]  req_tool,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_change_drive,
   output logic        rsp_fixing_drive,
   output logic        rsp_hold_drive,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_position,
   output logic [2:0]  rsp_steps_left,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tis_pkg::*;

   item_type item;
   cfg_type  cfg_ff;
   logic     item_valid, advance, rsp_vld_ff;

   // configuration writes always land at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.change_ticks <= CHANGE_TICKS_RST;
         cfg_ff.fix_ticks    <= FIX_TICKS_RST;
         cfg_ff.hold_variant <= HOLD_VARIANT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANGE_TICKS: cfg_ff.change_ticks <= csr_data;
            CSR_FIX_TICKS:    cfg_ff.fix_ticks    <= csr_data;
            CSR_HOLD_VARIANT: cfg_ff.hold_variant <= csr_data[0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // item moves on when the result slot is free or draining
   assign advance = item_valid && (!rsp_vld_ff || rsp_ready);

   tis_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_tool   (req_tool),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tis_update #(
      .POSITIONS (POSITIONS)
   ) u_update (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item),
      .cfg          (cfg_ff),
      .change_drive (rsp_change_drive),
      .fixing_drive (rsp_fixing_drive),
      .hold_drive   (rsp_hold_drive),
      .done_res     (rsp_done_res),
      .position     (rsp_position),
      .steps_left   (rsp_steps_left)
   );

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_vld_ff;

endmodule

// File: rtl/tis_checker.sv
// port-level checks of the turret index sequencer, bound to the top level
module tis_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_change_drive,
   input logic       rsp_fixing_drive,
   input logic       rsp_hold_drive,
   input logic       rsp_done_res,
   input logic [2:0] rsp_position,
   input logic [2:0] rsp_steps_left
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_steps_left) && $stable(rsp_done_res)
         && $stable(rsp_change_drive) && $stable(rsp_fixing_drive)
         && $stable(rsp_hold_drive))
   else $error("rsp changed while stalled");

   // committed position is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position != 3'd0)
   else $error("position zero");

   // done only once all steps are gone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_steps_left == 3'd0 && !rsp_change_drive)
   else $error("done with work left");

   // no result straight out of reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
   else $error("rsp valid after reset");

endmodule

bind turret_index_sequencer_core tis_checker u_tis_checker (.*);

// File: sim/testbench.sv
// self-checking testbench for the turret index sequencer core
`timescale 1ns / 1ps

import tis_pkg::*;

// one result transfer, field by field
typedef struct packed {
   logic              change_drive;
   logic              fixing_drive;
   logic              hold_drive;
   logic              done_res;
   logic [TOOL_W-1:0] position;
   logic [2:0]        steps_left;
} turret_outputs_type;

// tracks the sequencer state and holds the outputs still to come
class turret_tracker;
   logic [TICK_W-1:0] change_ticks;
   logic [TICK_W-1:0] fix_ticks;
   logic              hold_variant;

   logic [TOOL_W-1:0] cur_pos;
   phase_type         phase;
   logic [2:0]        remaining;
   logic [TICK_W-1:0] tick_cnt;
   logic              done_q;
   logic              change_q;
   logic              fixing_q;
   logic              hold_q;

   turret_outputs_type expected_outputs[$];
   int                 mismatches;

   function new();
      change_ticks = CHANGE_TICKS_RST;
      fix_ticks = FIX_TICKS_RST;
      hold_variant = HOLD_VARIANT_RST;
      cur_pos = 3'd1;
      phase = PH_IDLE;
      remaining = 3'd0;
      tick_cnt = '0;
      done_q = 1'b1;
      change_q = 1'b0;
      fixing_q = 1'b0;
      hold_q = 1'b1;
      mismatches = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [TICK_W-1:0] data);
      case (idx)
         CSR_CHANGE_TICKS: change_ticks = data;
         CSR_FIX_TICKS:    fix_ticks = data;
         CSR_HOLD_VARIANT: hold_variant = data[0];
         default: ;
      endcase
   endfunction

   // start of one index step: change phase, hold released on the hold board
   function void enter_change();
      phase = PH_CHANGE;
      tick_cnt = '0;
      if (hold_variant != VARIANT_FIXING)
         hold_q = 1'b0;
      change_q = 1'b1;
   endfunction

   // apply one accepted input item and queue the outputs it leaves
   function void apply_item(logic mode, logic [TOOL_W-1:0] tool);
      int                 steps;
      turret_outputs_type outs;
      if (mode == MODE_CMD) begin
         // out-of-range and same-position commands leave everything alone
         if (tool >= 1 && int'(tool) <= POSITIONS_DEF) begin
            if (tool >= cur_pos)
               steps = int'(tool) - int'(cur_pos);
            else
               steps = POSITIONS_DEF - (int'(cur_pos) - int'(tool));
            if (steps != 0) begin
               cur_pos = tool;
               remaining = steps[2:0];
               done_q = 1'b0;
               enter_change();
            end
         end
      end else begin
         case (phase)
            PH_CHANGE: begin
               if (tick_cnt != change_ticks)
                  tick_cnt = tick_cnt + 1'b1;
               else begin
                  phase = PH_FIX;
                  tick_cnt = '0;
                  change_q = 1'b0;
                  if (hold_variant == VARIANT_FIXING)
                     fixing_q = 1'b1;
               end
            end
            PH_FIX: begin
               if (tick_cnt != fix_ticks)
                  tick_cnt = tick_cnt + 1'b1;
               else begin
                  tick_cnt = '0;
                  if (hold_variant == VARIANT_FIXING)
                     fixing_q = 1'b0;
                  else
                     hold_q = 1'b1;
                  if (remaining > 0)
                     remaining = remaining - 1'b1;
                  if (remaining == 0) begin
                     phase = PH_IDLE;
                     done_q = 1'b1;
                  end else
                     enter_change();
               end
            end
            default: ;
         endcase
      end
      outs.change_drive = change_q;
      outs.fixing_drive = fixing_q;
      outs.hold_drive = hold_q;
      outs.done_res = done_q;
      outs.position = cur_pos;
      outs.steps_left = remaining;
      expected_outputs.push_back(outs);
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // compare one result transfer with the oldest expectation
   function void check_outputs(turret_outputs_type got);
      turret_outputs_type want;
      if (expected_outputs.size() == 0) begin
         mismatches++;
         $display("%0t: result with nothing expected, expected none actual %h", $time, got);
         return;
      end
      want = expected_outputs.pop_front();
      check_field("change_drive", want.change_drive, got.change_drive);
      check_field("fixing_drive", want.fixing_drive, got.fixing_drive);
      check_field("hold_drive", want.hold_drive, got.hold_drive);
      check_field("done_res", want.done_res, got.done_res);
      check_field("position", want.position, got.position);
      check_field("steps_left", want.steps_left, got.steps_left);
   endfunction

   function bit pending();
      return expected_outputs.size() != 0;
   endfunction

   // true while a phase timer is part way, a new top could strand it
   function bit counting();
      return tick_cnt != 0;
   endfunction

   function logic [TOOL_W-1:0] next_tool();
      return TOOL_W'(int'(cur_pos) % POSITIONS_DEF + 1);
   endfunction

   // ticks until the running sequence sets done
   function int ticks_left();
      int per_step;
      per_step = int'(change_ticks) + int'(fix_ticks) + 2;
      case (phase)
         PH_CHANGE: return int'(change_ticks) - int'(tick_cnt) + int'(fix_ticks) + 2
                           + (int'(remaining) - 1) * per_step;
         PH_FIX:    return int'(fix_ticks) - int'(tick_cnt) + 1
                           + (int'(remaining) - 1) * per_step;
         default:   return 0;
      endcase
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SEG_ITEMS = 66;
   localparam int RANDOM_SEGS = 8;
   localparam int DRAIN_CYCLES = 8;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_TICK;
   logic [TOOL_W-1:0]  req_tool = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_change_drive;
   logic               rsp_fixing_drive;
   logic               rsp_hold_drive;
   logic               rsp_done_res;
   logic [TOOL_W-1:0]  rsp_position;
   logic [2:0]         rsp_steps_left;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]  csr_data = '0;

   turret_tracker tracker = new();
   int            items_sent = 0;
   int            cycle_count = 0;
   bit            req_steady = 1'b0;
   bit            rsp_steady = 1'b0;

   turret_index_sequencer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_tool         (req_tool),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_change_drive (rsp_change_drive),
      .rsp_fixing_drive (rsp_fixing_drive),
      .rsp_hold_drive   (rsp_hold_drive),
      .rsp_done_res     (rsp_done_res),
      .rsp_position     (rsp_position),
      .rsp_steps_left   (rsp_steps_left),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      turret_outputs_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.change_drive = rsp_change_drive;
         got.fixing_drive = rsp_fixing_drive;
         got.hold_drive = rsp_hold_drive;
         got.done_res = rsp_done_res;
         got.position = rsp_position;
         got.steps_left = rsp_steps_left;
         tracker.check_outputs(got);
      end
   end

   // one input transfer after a random gap; valid stays high for a back-to-back item
   task automatic send_item(input logic mode, input logic [TOOL_W-1:0] tool);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode <= mode;
      req_tool <= tool;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      tracker.apply_item(mode, tool);
      items_sent++;
   endtask

   // write all three registers back to back
   task automatic write_cfg(input logic [TICK_W-1:0] change_top,
                            input logic [TICK_W-1:0] fix_top, input logic variant);
      logic [CSR_INDEX_W-1:0] regs[3];
      logic [TICK_W-1:0]      vals[3];
      regs = '{CSR_CHANGE_TICKS, CSR_FIX_TICKS, CSR_HOLD_VARIANT};
      vals = '{change_top, fix_top, {{(TICK_W-1){1'b0}}, variant}};
      for (int i = 0; i < 3; i++) begin
         csr_index <= regs[i];
         csr_data <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!(csr_valid && csr_ready));
         tracker.write_reg(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // end of a stimulus stretch: park the timer at zero, then wait for every result
   task automatic close_segment();
      if (tracker.counting())
         send_item(MODE_CMD, tracker.next_tool());
      req_valid <= 1'b0;
      while (tracker.pending()) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int seg_end;
      int burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ignored commands, idle tick, start, same tool while busy, restart
      send_item(MODE_TICK, 3'd5);
      send_item(MODE_CMD, 3'd0);
      send_item(MODE_CMD, 3'd7);
      send_item(MODE_CMD, 3'd1);
      send_item(MODE_CMD, 3'd4);
      send_item(MODE_TICK, 3'd2);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_CMD, 3'd4);
      send_item(MODE_CMD, 3'd2);
      send_item(MODE_TICK, 3'd7);
      close_segment();

      // one-tick phases: restart while fixing is driven, a move of five steps
      write_cfg(16'd0, 16'd0, VARIANT_FIXING);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_CMD, 3'd1);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_CMD, 3'd6);
      send_item(MODE_TICK, 3'd0);
      close_segment();

      // random stretches, each under its own settings
      for (int r = 0; r < RANDOM_SEGS; r++) begin
         case (r)
            0:       write_cfg(16'hFFFF, 16'hFFFF, 1'b1);
            1:       write_cfg(TICK_W'($urandom), TICK_W'($urandom),
                               1'($urandom_range(0, 1)));
            default: write_cfg(TICK_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)));
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         seg_end = items_sent + SEG_ITEMS;
         while (items_sent < seg_end) begin
            if ($urandom_range(0, 4) == 0)
               // noise: any mode, any tool
               send_item(1'($urandom_range(0, 1)), TOOL_W'($urandom_range(0, 7)));
            else begin
               // a valid command, then ticks to run it out, now and then cut short
               send_item(MODE_CMD, TOOL_W'($urandom_range(1, POSITIONS_DEF)));
               burst = tracker.ticks_left() + $urandom_range(0, 2);
               for (int k = 0; k < burst && items_sent < seg_end; k++) begin
                  if ($urandom_range(0, 24) == 0)
                     send_item(MODE_CMD, TOOL_W'($urandom_range(0, 7)));
                  else
                     send_item(MODE_TICK, TOOL_W'($urandom_range(0, 7)));
               end
            end
         end
         close_segment();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && !tracker.pending())
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tis_pkg.sv
rtl/tis_in_stage.sv
rtl/tis_update.sv
rtl/turret_index_sequencer_core.sv
rtl/tis_checker.sv
sim/testbench.sv
